### rtl/core/bbfa_pkg.sv
// Shared types and constants for the bump and best-fit allocator.
// No dependencies; the channel interfaces and the core import this package.
package bbfa_pkg;

	localparam int REQ_W = 24;
	localparam int ADDR_W = 64;
	localparam int IDX_W = 9;
	localparam int NEED_W = 25;
	localparam int POOL_W = 25;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 1;

	localparam logic [POOL_W-1:0] POOL_BYTES_RST = 25'd4194304;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_ZERO_SIZE    = 3'd1,
		ST_TABLE_FULL   = 3'd2,
		ST_NO_MEMORY    = 3'd3,
		ST_UNKNOWN_ADDR = 3'd4,
		ST_NULL_IGNORED = 3'd5
	} status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_BASE  = 1'b0,
		CFG_POOL_BYTES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEED,
		S_START,
		S_FIT,
		S_SCAN,
		S_SETTLE,
		S_DONE
	} state_t;

endpackage

### rtl/core/bbfa_channels.sv
// Valid/ready channel interfaces for allocator requests and results.
// Depends on bbfa_pkg for field widths and codes.
interface bbfa_item_if;
	import bbfa_pkg::*;

	logic                valid;
	logic                ready;
	action_t             action;
	logic [REQ_W-1:0]    request_bytes;
	logic [ADDR_W-1:0]   address;

	modport source(output valid, action, request_bytes, address, input ready);
	modport sink(input valid, action, request_bytes, address, output ready);
endinterface

interface bbfa_result_if;
	import bbfa_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [ADDR_W-1:0]   region_address;
	logic [IDX_W-1:0]    entry_index;
	logic                reused;

	modport source(output valid, status, region_address, entry_index, reused, input ready);
	modport sink(input valid, status, region_address, entry_index, reused, output ready);
endinterface

### rtl/core/bbfa_align_unit.sv
// Registered round-up to a multiple of ALIGN_BYTES, which must be a power of two.
// Depends on nothing; shared by the size and bump offset alignment steps.
module bbfa_align_unit #(
	parameter int ALIGN_BYTES = 64,
	parameter int XW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] value,
	output logic          done,
	output logic [XW-1:0] rounded
);
	localparam logic [XW-1:0] LOW_MASK = XW'(ALIGN_BYTES - 1);

	logic          done_q;
	logic [XW-1:0] rounded_q;

	assign done = done_q;
	assign rounded = rounded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rounded_q <= (value + LOW_MASK) & ~LOW_MASK;
		end
	end
endmodule

### rtl/core/bbfa_entry_table.sv
// Region table memory: one write port and one registered read port.
// Each word packs the used flag, the region size and the region offset.
module bbfa_entry_table #(
	parameter int DEPTH = 512,
	parameter int IW = 9,
	parameter int WW = 51
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [WW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [WW-1:0] rdata
);
	logic [WW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/bump_and_best_fit_allocator_core.sv
// Bump allocator with best-fit reuse of freed regions; top level and sequencer.
// A bump allocation passes through two align steps and the fit check before its result is loaded.
// A reuse goes on to a table scan and a settle step, and a free scans and settles; one table read per cycle.
// One transfer is in progress at a time; a finished result waits in the output register,
// and the next transfer can be accepted in the cycle after the result is loaded.
// Reset clears the count, bump offset and pool registers (pool size 4 MiB); no table clear pass.
module bump_and_best_fit_allocator_core #(
	parameter int MAX_ENTRIES = 512,
	parameter int ALIGN_BYTES = 64,
	parameter int OFFSET_BITS = 25
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bbfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bbfa_pkg::CFG_DATA_W-1:0]    cfg_data,
	bbfa_item_if.sink                          item,
	bbfa_result_if.source                      result
);
	import bbfa_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int OW = OFFSET_BITS;
	localparam int XW = (OW + 1 > NEED_W) ? OW + 1 : NEED_W;
	localparam int MW = (OW > NEED_W) ? OW : NEED_W;
	localparam int SW = XW + 1;
	localparam int WW = 2 * OW + 1;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] pool_base_q;
	logic [POOL_W-1:0] pool_bytes_q;
	logic [CW-1:0]     count_q;
	logic [OW-1:0]     bump_q;

	action_t           act_q;
	logic [ADDR_W-1:0] diff_q;
	logic [NEED_W-1:0] need_q;
	logic [XW-1:0]     start_q;

	logic [CW-1:0]     rd_ptr_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;

	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [OW-1:0]     hit_off_q;
	logic [OW-1:0]     hit_size_q;
	logic [MW-1:0]     best_d_q;

	status_t           res_status_q;
	logic [IW-1:0]     res_idx_q;
	logic [OW-1:0]     res_off_q;
	logic              res_addr_en_q;
	logic              res_reused_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_reused_q;

	logic              accept;
	logic              al_start;
	logic [XW-1:0]     al_value;
	logic              al_done;
	logic [XW-1:0]     al_rounded;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [WW-1:0]     mem_wdata;
	logic [WW-1:0]     mem_rdata;
	logic [SW-1:0]     end_sum;
	logic              bump_fits;
	logic              scan_issue;
	logic              out_load;

	logic              rd_used;
	logic [OW-1:0]     rd_size;
	logic [OW-1:0]     rd_off;
	logic [MW-1:0]     size_ext;
	logic [MW-1:0]     need_ext;
	logic [MW-1:0]     spare;
	logic              take;

	bbfa_align_unit #(
		.ALIGN_BYTES(ALIGN_BYTES),
		.XW(XW)
	) u_align (
		.clk(clk),
		.arst_n(arst_n),
		.start(al_start),
		.value(al_value),
		.done(al_done),
		.rounded(al_rounded)
	);

	bbfa_entry_table #(
		.DEPTH(MAX_ENTRIES),
		.IW(IW),
		.WW(WW)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_ptr_q[IW-1:0]),
		.rdata(mem_rdata)
	);

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign end_sum = SW'(start_q) + SW'(need_q);
	assign bump_fits = (end_sum <= SW'(pool_bytes_q));
	assign scan_issue = (rd_ptr_q < count_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	assign rd_used = mem_rdata[WW-1];
	assign rd_size = mem_rdata[2*OW-1:OW];
	assign rd_off = mem_rdata[OW-1:0];
	assign size_ext = MW'(rd_size);
	assign need_ext = MW'(need_q);
	assign spare = size_ext - need_ext;

	always_comb begin
		take = 1'b0;
		if (vld_s1) begin
			if (act_q == ACT_FREE) begin
				take = !hit_q && rd_used && (ADDR_W'(rd_off) == diff_q);
			end else begin
				take = !rd_used && (size_ext >= need_ext) && (!hit_q || (spare < best_d_q));
			end
		end
	end

	always_comb begin
		state_d = state_q;
		al_start = 1'b0;
		al_value = XW'(item.request_bytes);
		mem_we = 1'b0;
		mem_waddr = count_q[IW-1:0];
		mem_wdata = {1'b1, OW'(need_q), start_q[OW-1:0]};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.action == ACT_FREE) begin
						state_d = (item.address == '0) ? S_DONE : S_SCAN;
					end else if ((item.request_bytes == '0) ||
						(count_q >= CW'(MAX_ENTRIES))) begin
						state_d = S_DONE;
					end else begin
						al_start = 1'b1;
						state_d = S_NEED;
					end
				end
			end
			S_NEED: begin
				if (al_done) begin
					al_start = 1'b1;
					al_value = XW'(bump_q);
					state_d = S_START;
				end
			end
			S_START: begin
				if (al_done) begin
					state_d = S_FIT;
				end
			end
			S_FIT: begin
				if (bump_fits) begin
					mem_we = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!scan_issue && !vld_s1) begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				mem_we = hit_q;
				mem_waddr = hit_idx_q;
				mem_wdata = {(act_q == ACT_ALLOC), hit_size_q, hit_off_q};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_bytes_q <= POOL_BYTES_RST;
			count_q <= '0;
			bump_q <= '0;
			rd_ptr_q <= '0;
			vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_POOL_BASE) begin
					pool_base_q <= cfg_data;
				end else if (cfg_index == CFG_POOL_BYTES) begin
					pool_bytes_q <= cfg_data[POOL_W-1:0];
				end
			end
			if ((state_q == S_FIT) && bump_fits) begin
				count_q <= count_q + 1'b1;
				bump_q <= end_sum[OW-1:0];
			end
			if ((state_d == S_SCAN) && (state_q != S_SCAN)) begin
				rd_ptr_q <= '0;
				hit_q <= 1'b0;
			end else if ((state_q == S_SCAN) && scan_issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (take) begin
				hit_q <= 1'b1;
			end
			vld_s1 <= (state_q == S_SCAN) && scan_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[IW-1:0];
		if (accept) begin
			act_q <= item.action;
			diff_q <= item.address - pool_base_q;
			res_idx_q <= '0;
			res_off_q <= '0;
			res_addr_en_q <= 1'b0;
			res_reused_q <= 1'b0;
			if (item.action == ACT_FREE) begin
				res_status_q <= (item.address == '0) ? ST_NULL_IGNORED : ST_OK;
			end else if (item.request_bytes == '0) begin
				res_status_q <= ST_ZERO_SIZE;
			end else if (count_q >= CW'(MAX_ENTRIES)) begin
				res_status_q <= ST_TABLE_FULL;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if ((state_q == S_NEED) && al_done) begin
			need_q <= NEED_W'(al_rounded);
		end
		if ((state_q == S_START) && al_done) begin
			start_q <= al_rounded;
		end
		if ((state_q == S_FIT) && bump_fits) begin
			res_idx_q <= count_q[IW-1:0];
			res_off_q <= start_q[OW-1:0];
			res_addr_en_q <= 1'b1;
		end
		if (take) begin
			hit_idx_q <= idx_s1;
			hit_off_q <= rd_off;
			hit_size_q <= rd_size;
			best_d_q <= spare;
		end
		if (state_q == S_SETTLE) begin
			if (hit_q) begin
				res_status_q <= ST_OK;
				res_idx_q <= hit_idx_q;
				if (act_q == ACT_ALLOC) begin
					res_off_q <= hit_off_q;
					res_addr_en_q <= 1'b1;
					res_reused_q <= 1'b1;
				end
			end else begin
				res_status_q <= (act_q == ACT_FREE) ? ST_UNKNOWN_ADDR : ST_NO_MEMORY;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_addr_q <= res_addr_en_q ? (pool_base_q + ADDR_W'(res_off_q)) : '0;
			out_idx_q <= IDX_W'(res_idx_q);
			out_reused_q <= res_reused_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_status_q;
	assign result.region_address = out_addr_q;
	assign result.entry_index = out_idx_q;
	assign result.reused = out_reused_q;
endmodule
